// ----- hdl/bfd_pkg.sv -----
package bfd_pkg;

    // Register indexes on the configuration port (byte address = 4 * index)
    localparam logic [1:0] REG_DECODE_MODE = 2'd0;
    localparam logic [1:0] REG_MIN_LENGTH  = 2'd1;
    localparam logic [1:0] REG_SEQ_MASK    = 2'd2;
    localparam logic [1:0] REG_ERR_CODE    = 2'd3;

    // Summary status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_RESERVED  = 3'd2;
    localparam logic [2:0] ST_HDR_SIZE  = 3'd3;
    localparam logic [2:0] ST_FIELDS    = 3'd4;
    localparam logic [2:0] ST_PAYLOAD   = 3'd5;

    localparam logic [4:0] POS_MAX      = 5'd31;
    localparam int         TDATA_W      = 104;

    typedef struct packed {
        logic       decode_mode;
        logic [4:0] min_length;
        logic [3:0] seq_mask;
        logic [3:0] err_code;
    } t_cfg;

    typedef struct packed {
        logic [32:0] payload_size;
        logic [31:0] sequence_number;
        logic [3:0]  compression;
        logic [3:0]  serialization;
        logic [3:0]  flag_bits;
        logic [3:0]  message_type;
        logic [3:0]  header_bytes;
        logic [3:0]  version;
        logic [2:0]  status;
        logic        summary_flag;
        logic [7:0]  payload_byte;
    } t_result;

    // Results caused by one accepted item: up to a payload byte and a summary
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

// ----- hdl/bfd_regs.sv -----
module bfd_regs
    import bfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decode_mode <= 1'b0;
            r_cfg.min_length  <= 5'd8;
            r_cfg.seq_mask    <= 4'd1;
            r_cfg.err_code    <= 4'd15;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_DECODE_MODE: r_cfg.decode_mode <= pwdata[0];
                REG_MIN_LENGTH:  r_cfg.min_length  <= pwdata[4:0];
                REG_SEQ_MASK:    r_cfg.seq_mask    <= pwdata[3:0];
                REG_ERR_CODE:    r_cfg.err_code    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DECODE_MODE: prdata = {31'd0, r_cfg.decode_mode};
            REG_MIN_LENGTH:  prdata = {27'd0, r_cfg.min_length};
            REG_SEQ_MASK:    prdata = {28'd0, r_cfg.seq_mask};
            REG_ERR_CODE:    prdata = {28'd0, r_cfg.err_code};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// ----- hdl/bfd_parser.sv -----
module bfd_parser
    import bfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_eom,
    input  t_cfg       i_cfg,
    output t_push      o_push
);

    typedef enum logic [7:0] {
        PH_HEADER  = 8'b0000_0001,
        PH_SEQ     = 8'b0000_0010,
        PH_SKIP    = 8'b0000_0100,
        PH_LEN     = 8'b0000_1000,
        PH_ERRHEAD = 8'b0001_0000,
        PH_PAYLOAD = 8'b0010_0000,
        PH_DONE    = 8'b0100_0000,
        PH_IGNORE  = 8'b1000_0000
    } t_phase;

    function automatic logic [3:0] size_bytes(input logic [3:0] f);
        return (f < 4'd4) ? {f[1:0], 2'b00} : f;
    endfunction

    t_phase      r_phase, n_phase;
    logic [4:0]  r_pos, n_pos;
    logic [23:0] r_hdr, n_hdr;
    logic        r_rbad, n_rbad;
    logic [3:0]  r_ws, n_ws;
    logic [31:0] r_seq, n_seq;
    logic [31:0] r_len, n_len;
    logic [31:0] r_remain, n_remain;
    logic        r_is_err, n_is_err;
    logic        r_seq_rd, n_seq_rd;

    logic [3:0]  ws_inc;
    logic [3:0]  hsize;
    logic        size_ok;
    logic        emit;
    logic        is_short;
    logic [2:0]  st;
    t_result     pay_res;
    t_result     sum_res;

    assign ws_inc = r_ws + 4'd1;
    assign hsize  = size_bytes(r_hdr[19:16]);
    assign size_ok = (hsize == 4'd4) || (hsize == 4'd8);

    always_comb begin
        n_phase  = r_phase;
        n_hdr    = r_hdr;
        n_rbad   = r_rbad;
        n_ws     = r_ws;
        n_seq    = r_seq;
        n_len    = r_len;
        n_remain = r_remain;
        n_is_err = r_is_err;
        n_seq_rd = r_seq_rd;
        emit     = 1'b0;

        case (r_phase)
            PH_HEADER: begin
                case (r_pos)
                    5'd0: n_hdr[23:16] = i_byte;
                    5'd1: n_hdr[15:8]  = i_byte;
                    5'd2: n_hdr[7:0]   = i_byte;
                    default: begin
                        // Reserved byte closes the header; pick the body layout
                        n_rbad = (i_byte != 8'h00);
                        n_ws   = 4'd0;
                        if (!i_cfg.decode_mode) begin
                            if (n_rbad) begin
                                n_phase = PH_IGNORE;
                            end else if (r_hdr[15:12] == i_cfg.err_code) begin
                                n_is_err = 1'b1;
                                n_phase  = PH_ERRHEAD;
                            end else if (!size_ok) begin
                                n_phase = PH_IGNORE;
                            end else if ((r_hdr[11:8] & i_cfg.seq_mask) != 4'd0) begin
                                n_seq_rd = 1'b1;
                                n_phase  = PH_SEQ;
                            end else begin
                                n_phase = PH_LEN;
                            end
                        end else begin
                            if (!size_ok)              n_phase = PH_IGNORE;
                            else if (hsize == 4'd8)    n_phase = PH_SKIP;
                            else                       n_phase = PH_LEN;
                        end
                    end
                endcase
            end
            PH_SEQ: begin
                n_seq = {r_seq[23:0], i_byte};
                if (ws_inc >= 4'd4) begin
                    n_ws    = 4'd0;
                    n_phase = PH_LEN;
                end else begin
                    n_ws = ws_inc;
                end
            end
            PH_SKIP: begin
                if (ws_inc >= 4'd4) begin
                    n_ws    = 4'd0;
                    n_phase = PH_LEN;
                end else begin
                    n_ws = ws_inc;
                end
            end
            PH_LEN: begin
                n_len = {r_len[23:0], i_byte};
                if (ws_inc >= 4'd4) begin
                    n_ws     = 4'd0;
                    n_remain = n_len;
                    n_phase  = (n_len == 32'd0) ? PH_DONE : PH_PAYLOAD;
                end else begin
                    n_ws = ws_inc;
                end
            end
            PH_ERRHEAD: begin
                // Error code word and text length word both pass as payload
                emit = 1'b1;
                if (r_ws >= 4'd4) n_len = {r_len[23:0], i_byte};
                if (ws_inc >= 4'd8) begin
                    n_ws     = 4'd0;
                    n_remain = n_len;
                    n_phase  = (n_len == 32'd0) ? PH_DONE : PH_PAYLOAD;
                end else begin
                    n_ws = ws_inc;
                end
            end
            PH_PAYLOAD: begin
                emit     = 1'b1;
                n_remain = r_remain - 32'd1;
                if (r_remain == 32'd1) n_phase = PH_DONE;
            end
            default: ;
        endcase

        // Saturate: every length compare is against at most 31
        n_pos = (r_pos == POS_MAX) ? POS_MAX : r_pos + 5'd1;
    end

    always_comb begin
        if (!i_cfg.decode_mode)
            is_short = (n_pos < i_cfg.min_length) || (n_pos < 5'd4);
        else
            is_short = (n_pos < 5'd8);

        if (is_short)                     st = ST_SHORT;
        else if (n_phase == PH_IGNORE)    st = (!i_cfg.decode_mode && n_rbad) ? ST_RESERVED
                                                                              : ST_HDR_SIZE;
        else if (n_phase == PH_PAYLOAD)   st = ST_PAYLOAD;
        else if (n_phase == PH_DONE)      st = ST_OK;
        else                              st = ST_FIELDS;

        pay_res              = '0;
        pay_res.payload_byte = i_byte;

        sum_res               = '0;
        sum_res.summary_flag  = 1'b1;
        sum_res.status        = st;
        sum_res.version       = n_hdr[23:20];
        sum_res.header_bytes  = n_seq_rd ? 4'd8 : size_bytes(n_hdr[19:16]);
        sum_res.message_type  = n_hdr[15:12];
        sum_res.flag_bits     = n_hdr[11:8];
        sum_res.serialization = n_hdr[7:4];
        sum_res.compression   = n_hdr[3:0];
        if (st == ST_OK) begin
            sum_res.sequence_number = n_seq;
            sum_res.payload_size    = r_is_err || n_is_err ? {1'b0, n_len} + 33'd8
                                                           : {1'b0, n_len};
        end

        o_push.res0 = emit ? pay_res : sum_res;
        o_push.res1 = sum_res;
        if (!i_valid)  o_push.num = 2'd0;
        else           o_push.num = {1'b0, emit} + {1'b0, i_eom};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_eom)) begin
            r_phase  <= PH_HEADER;
            r_pos    <= 5'd0;
            r_hdr    <= 24'd0;
            r_rbad   <= 1'b0;
            r_ws     <= 4'd0;
            r_seq    <= 32'd0;
            r_len    <= 32'd0;
            r_remain <= 32'd0;
            r_is_err <= 1'b0;
            r_seq_rd <= 1'b0;
        end else if (i_valid) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_hdr    <= n_hdr;
            r_rbad   <= n_rbad;
            r_ws     <= n_ws;
            r_seq    <= n_seq;
            r_len    <= n_len;
            r_remain <= n_remain;
            r_is_err <= n_is_err;
            r_seq_rd <= n_seq_rd;
        end
    end

endmodule

// ----- hdl/bfd_outq.sv -----
module bfd_outq
    import bfd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_push                      i_push,
    input  logic                       i_ready,
    output logic                       o_valid,
    output t_result                    o_head,
    output logic [$clog2(DEPTH+1)-1:0] o_level
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    t_result       r_q [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] wr1;
    logic          pop;

    assign wr1     = ptr_inc(r_wr);
    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_head  = r_q[r_rd];
    assign o_level = r_count;

    always_comb begin
        n_rd    = pop ? ptr_inc(r_rd) : r_rd;
        n_count = r_count + CW'(i_push.num) - CW'(pop);
        case (i_push.num)
            2'd1:    n_wr = wr1;
            2'd2:    n_wr = ptr_inc(wr1);
            default: n_wr = r_wr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) r_q[r_wr] <= i_push.res0;
        if (i_push.num == 2'd2) r_q[wr1]  <= i_push.res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ----- hdl/binary_frame_header_deframer.sv -----
// Channel   Dir  tdata (low bit up)                                  tlast / other
// s_axis    in   data_byte[7:0]                                      end_of_message
// m_axis    out  payload_byte, status, version, header_bytes, ...    summary_flag
// apb       in   decode_mode @0x0, min_length @0x4, seq mask @0x8, error type @0xC
//
// One byte is taken per cycle while s_axis_tready is high; its results are written
// to the output queue at the same edge, and the first can be taken on m_axis at the
// following edge. A byte may cause two results (last payload byte plus summary); the
// queue drains one per cycle while m_axis_tready is high, so a message that ends on a
// payload byte can make s_axis_tready drop.
// s_axis_tready drops while fewer than two queue slots are free.
// Synchronous active-low reset clears the parser and empties the queue.
module binary_frame_header_deframer
    import bfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,   // data_byte
    input  logic               i_s_axis_tlast,   // end_of_message
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // payload_byte[7:0], status[10:8], version[14:11], header_bytes[18:15],
    // message_type[22:19], flag_bits[26:23], serialization[30:27],
    // compression[34:31], sequence_number[66:35], payload_size[99:67], zeros
    output logic [TDATA_W-1:0] o_m_axis_tdata,
    output logic               o_m_axis_tlast,   // summary_flag
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cfg          cfg;
    t_push         push;
    t_result       head;
    logic [CW-1:0] level;
    logic          in_acc;

    // Room for the worst case of two results per byte
    assign o_s_axis_tready = (level <= CW'(QUEUE_DEPTH - 2));
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    bfd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bfd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_acc),
        .i_byte  (i_s_axis_tdata),
        .i_eom   (i_s_axis_tlast),
        .i_cfg   (cfg),
        .o_push  (push)
    );

    bfd_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_head  (head),
        .o_level (level)
    );

    assign o_m_axis_tlast = head.summary_flag;
    assign o_m_axis_tdata = {4'd0, head.payload_size, head.sequence_number,
                             head.compression, head.serialization, head.flag_bits,
                             head.message_type, head.header_bytes, head.version,
                             head.status, head.payload_byte};

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level <= CW'(QUEUE_DEPTH))
        else $error("output queue overflow");

    a_eom_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_axis_tlast) |-> (push.num != 2'd0) && push.res1.summary_flag)
        else $error("end of message produced no summary");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.num != 2'd0) |=> (level != '0))
        else $error("pushed result not in queue");

endmodule
